// ----- rtl/flsp_pkg.sv -----
// ----------------------------------------------------------------------------
// flsp_pkg
// Shared types and constants for the five-stage load/store pipeline.
// ----------------------------------------------------------------------------
package flsp_pkg;

  localparam int ADDR_W     = 10;
  localparam int CMD_W      = 3;
  localparam int NREGS      = 32;
  localparam int IMEM_BYTES = 1024;
  localparam int DMEM_BYTES = 1024;

  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WR_INSTR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WR_DATA  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RD_REG   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RD_DATA  = 3'd4;

  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_JUMP  = 6'd2;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;
  localparam logic [5:0] FN_SUBU  = 6'h23;

  localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

  // empty flag bit positions
  localparam int E_IF  = 0;
  localparam int E_ID  = 1;
  localparam int E_EX  = 2;
  localparam int E_MEM = 3;
  localparam int E_WB  = 4;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       word;
  } bm_wr_t;

  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] value;
  } rf_wr_t;

  typedef struct packed {
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [15:0] imm;
    logic [4:0]  dest;
    logic        is_imm;
    logic        load;
    logic        store;
    logic        add_sel;
    logic        reg_wr;
  } ex_latch_t;

  typedef struct packed {
    logic [31:0] alu;
    logic [31:0] store_val;
    logic [4:0]  dest;
    logic        load;
    logic        store;
    logic        reg_wr;
  } mem_latch_t;

  typedef struct packed {
    logic [31:0] value;
    logic [4:0]  dest;
    logic        reg_wr;
  } wb_latch_t;

endpackage

// ----- rtl/flsp_bytemem.sv -----
// ----------------------------------------------------------------------------
// flsp_bytemem
// Byte-addressed big-endian word memory in four byte banks. Unaligned words
// wrap modulo the size. Registered read, write-to-read forwarding,
// zero-fill pass after reset.
// ----------------------------------------------------------------------------
module flsp_bytemem #(
  parameter int BYTES = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [flsp_pkg::ADDR_W-1:0] rd_addr,
  output logic [31:0]                rd_word,
  input  flsp_pkg::bm_wr_t           wr,
  output logic                       busy
);
  import flsp_pkg::*;

  localparam int ROWS = BYTES / 4;
  localparam int RW   = $clog2(ROWS);

  logic [RW-1:0] rd_row [4];
  logic [RW-1:0] wr_row [4];
  logic [7:0]    wr_byte [4];
  logic [7:0]    q_byte [4];
  logic [7:0]    f_byte [4];
  logic [1:0]    lo_q;
  logic [RW-1:0] clr_row;
  logic          fwd_en;
  logic [1:0]    wi;

  always_comb begin
    wi = '0;
    for (int k = 0; k < 4; k++) begin
      rd_row[k] = rd_addr[RW+1:2] + {{(RW-1){1'b0}}, (2'(k) < rd_addr[1:0])};
      wr_row[k] = wr.addr[RW+1:2] + {{(RW-1){1'b0}}, (2'(k) < wr.addr[1:0])};
      wi = 2'(k) - wr.addr[1:0];
      wr_byte[k] = wr.word[(5'd24 - {wi, 3'b000}) +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == RW'(ROWS - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_en <= 1'b0;
    end else begin
      fwd_en <= wr.en && !busy;
    end
  end

  always_ff @(posedge clk) begin
    lo_q <= rd_addr[1:0];
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [7:0]    q;
    logic [RW-1:0] rd_row_q;
    logic [RW-1:0] fwd_row;
    logic [7:0]    fwd_byte;

    always_ff @(posedge clk) begin
      if (busy) begin
        mem[clr_row] <= '0;
      end else if (wr.en) begin
        mem[wr_row[k]] <= wr_byte[k];
      end
      q        <= mem[rd_row[k]];
      rd_row_q <= rd_row[k];
      fwd_row  <= wr_row[k];
      fwd_byte <= wr_byte[k];
    end

    assign q_byte[k] = (fwd_en && fwd_row == rd_row_q) ? fwd_byte : q;
    assign f_byte[k] = q_byte[k];
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < 4; i++) begin
      rd_word[8*(3-i) +: 8] = f_byte[2'(lo_q + 2'(i))];
    end
  end

endmodule

// ----- rtl/flsp_regfile.sv -----
// ----------------------------------------------------------------------------
// flsp_regfile
// 32 x 32 register file, two registered read ports, one write port, valid
// bits so unwritten registers read as zero, forwarding of last write.
// ----------------------------------------------------------------------------
module flsp_regfile (
  input  logic             clk,
  input  logic             rst,
  input  logic [4:0]       ra_a,
  input  logic [4:0]       ra_b,
  output logic [31:0]      rd_a,
  output logic [31:0]      rd_b,
  input  flsp_pkg::rf_wr_t wr
);
  import flsp_pkg::*;

  logic [31:0]      mem [NREGS];
  logic [NREGS-1:0] vld;
  logic [31:0]      q_a, q_b;
  logic [4:0]       qa_idx, qb_idx;
  logic             va_q, vb_q;
  logic             fwd_en;
  logic [4:0]       fwd_idx;
  logic [31:0]      fwd_val;

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.idx] <= wr.value;
    q_a     <= mem[ra_a];
    q_b     <= mem[ra_b];
    qa_idx  <= ra_a;
    qb_idx  <= ra_b;
    fwd_idx <= wr.idx;
    fwd_val <= wr.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      fwd_en <= 1'b0;
    end else begin
      if (wr.en) vld[wr.idx] <= 1'b1;
      va_q   <= vld[ra_a];
      vb_q   <= vld[ra_b];
      fwd_en <= wr.en;
    end
  end

  assign rd_a = (fwd_en && fwd_idx == qa_idx) ? fwd_val : (va_q ? q_a : '0);
  assign rd_b = (fwd_en && fwd_idx == qb_idx) ? fwd_val : (vb_q ? q_b : '0);

endmodule

// ----- rtl/five_stage_load_store_pipeline.sv -----
// ----------------------------------------------------------------------------
// five_stage_load_store_pipeline
// Command-driven five-stage in-order pipeline model with memories.
// ----------------------------------------------------------------------------
// One command item is taken per clock while in_stall is low. An item first
// issues reads to the instruction memory, data memory and register file
// (addresses come from the state the previous item leaves) and is then
// computed and written back into the output register; a new item can be
// taken while it commits. After reset both byte memories run a zero-fill
// pass during which no item is accepted; a held item facing a stalled output also blocks input.
module five_stage_load_store_pipeline (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [flsp_pkg::CMD_W-1:0]    command,
  input  logic [flsp_pkg::ADDR_W-1:0]   address,
  input  logic [31:0]                   write_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   read_data,
  output logic                          done_res,
  output logic [31:0]                   fetch_pc,
  output logic                          reg_write_valid,
  output logic [4:0]                    reg_write_index,
  output logic [31:0]                   reg_write_value,
  output logic                          mem_write_valid,
  output logic [flsp_pkg::ADDR_W-1:0]   mem_write_address,
  output logic [31:0]                   mem_write_value
);
  import flsp_pkg::*;

  // commit stage
  logic              b_valid;
  logic [CMD_W-1:0]  b_cmd;
  logic [ADDR_W-1:0] b_addr;
  logic [31:0]       b_wdata;
  logic              b_go, in_acc, busy_i, busy_d;

  // pipeline state
  logic [31:0] pc, pc_next;
  logic [4:0]  flags, flags_next;
  logic [31:0] dl, dl_next;
  ex_latch_t   ex, ex_next;
  mem_latch_t  ml, ml_next;
  wb_latch_t   wb, wb_next;

  logic [CMD_W-1:0]  sel_cmd;
  logic [ADDR_W-1:0] sel_addr;
  logic [ADDR_W-1:0] im_raddr, dm_raddr;
  logic [4:0]        rf_ra_a, rf_ra_b;
  logic [31:0]       im_word, dm_word, rf_a, rf_b;
  bm_wr_t            im_wr, dm_wr;
  rf_wr_t            rf_wr;

  logic [31:0]       r_read;
  logic              r_done, r_mwv;
  logic [ADDR_W-1:0] r_mwa;
  logic [31:0]       r_mwval;

  logic        wb_hit;
  logic [31:0] opb;
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt;
  logic        br, imm_form;

  assign b_go     = b_valid && (!out_valid || !out_stall);
  assign in_stall = busy_i || busy_d || (b_valid && !b_go);
  assign in_acc   = in_valid && !in_stall;

  // read addresses for the item entering, taken from the state after commit
  assign sel_cmd  = in_acc ? command : b_cmd;
  assign sel_addr = in_acc ? address : b_addr;
  assign im_raddr = pc_next[ADDR_W-1:0];
  assign dm_raddr = (sel_cmd == CMD_RD_DATA) ? sel_addr : ml_next.alu[ADDR_W-1:0];
  assign rf_ra_a  = (sel_cmd == CMD_RD_REG) ? sel_addr[4:0] : dl_next[25:21];
  assign rf_ra_b  = dl_next[20:16];

  flsp_bytemem #(.BYTES(IMEM_BYTES)) u_imem (
    .clk(clk), .rst(rst), .rd_addr(im_raddr), .rd_word(im_word), .wr(im_wr), .busy(busy_i)
  );

  flsp_bytemem #(.BYTES(DMEM_BYTES)) u_dmem (
    .clk(clk), .rst(rst), .rd_addr(dm_raddr), .rd_word(dm_word), .wr(dm_wr), .busy(busy_d)
  );

  flsp_regfile u_rf (
    .clk(clk), .rst(rst), .ra_a(rf_ra_a), .ra_b(rf_ra_b), .rd_a(rf_a), .rd_b(rf_b), .wr(rf_wr)
  );

  always_comb begin
    pc_next    = pc;
    flags_next = flags;
    dl_next    = dl;
    ex_next    = ex;
    ml_next    = ml;
    wb_next    = wb;
    im_wr      = '0;
    dm_wr      = '0;
    rf_wr      = '0;
    r_read     = '0;
    r_done     = 1'b0;
    r_mwv      = 1'b0;
    r_mwa      = '0;
    r_mwval    = '0;
    wb_hit     = 1'b0;
    opb        = '0;
    op         = dl[31:26];
    fn         = dl[5:0];
    rs         = dl[25:21];
    rt         = dl[20:16];
    br         = 1'b0;
    imm_form   = 1'b0;
    if (b_go) begin
      unique case (b_cmd)
        CMD_TICK: begin
          r_done     = (flags == 5'b11111);
          flags_next = '0;
          wb_hit     = !flags[E_WB] && wb.reg_wr;
          if (wb_hit) rf_wr = '{en: 1'b1, idx: wb.dest, value: wb.value};

          if (flags[E_MEM]) begin
            flags_next[E_WB] = 1'b1;
          end else begin
            if (ml.store) begin
              dm_wr   = '{en: 1'b1, addr: ml.alu[ADDR_W-1:0], word: ml.store_val};
              r_mwv   = 1'b1;
              r_mwa   = ml.alu[ADDR_W-1:0];
              r_mwval = ml.store_val;
            end
            wb_next.value  = ml.load ? dm_word : ml.alu;
            wb_next.dest   = ml.dest;
            wb_next.reg_wr = ml.reg_wr;
          end

          if (flags[E_EX]) begin
            flags_next[E_MEM] = 1'b1;
          end else begin
            opb = ex.is_imm ? {{16{ex.imm[15]}}, ex.imm} : ex.op_b;
            ml_next.alu       = ex.add_sel ? ex.op_a + opb : ex.op_a - opb;
            ml_next.store_val = ex.op_b;
            ml_next.load      = ex.load;
            ml_next.store     = ex.store;
            ml_next.dest      = ex.dest;
            ml_next.reg_wr    = ex.reg_wr;
          end

          if (flags[E_ID]) begin
            flags_next[E_EX] = 1'b1;
          end else begin
            br       = (op == OP_BEQ);
            imm_form = (op != OP_RTYPE) && (op != OP_JUMP);
            ex_next.load    = (op == OP_LW);
            ex_next.store   = (op == OP_SW);
            ex_next.reg_wr  = !((op == OP_SW) || br);
            ex_next.is_imm  = imm_form && !br;
            ex_next.add_sel = !((op == OP_RTYPE) && (fn == FN_SUBU));
            // writeback lands before decode reads
            ex_next.op_a = (wb_hit && wb.dest == rs) ? wb.value : rf_a;
            ex_next.op_b = (wb_hit && wb.dest == rt) ? wb.value : rf_b;
            ex_next.dest = (imm_form && !br) ? rt : dl[15:11];
            ex_next.imm  = dl[15:0];
          end

          if (flags[E_IF]) begin
            flags_next[E_ID] = 1'b1;
            flags_next[E_IF] = 1'b1;
          end else begin
            dl_next = im_word;
            pc_next = pc + 32'd4;
            if (im_word == HALT_WORD) begin
              pc_next          = pc;
              flags_next[E_ID] = 1'b1;
              flags_next[E_IF] = 1'b1;
            end
          end
        end
        CMD_WR_INSTR: im_wr = '{en: 1'b1, addr: b_addr, word: b_wdata};
        CMD_WR_DATA:  dm_wr = '{en: 1'b1, addr: b_addr, word: b_wdata};
        CMD_RD_REG:   r_read = rf_a;
        CMD_RD_DATA:  r_read = dm_word;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
      pc        <= '0;
      flags     <= 5'b11110;
      ex        <= '{add_sel: 1'b1, default: '0};
    end else begin
      if (in_acc)    b_valid <= 1'b1;
      else if (b_go) b_valid <= 1'b0;
      if (b_go)            out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      pc    <= pc_next;
      flags <= flags_next;
      ex    <= ex_next;
    end
  end

  always_ff @(posedge clk) begin
    dl <= dl_next;
    ml <= ml_next;
    wb <= wb_next;
    if (in_acc) begin
      b_cmd   <= command;
      b_addr  <= address;
      b_wdata <= write_data;
    end
    if (b_go) begin
      read_data         <= r_read;
      done_res          <= r_done;
      fetch_pc          <= pc_next;
      reg_write_valid   <= rf_wr.en;
      reg_write_index   <= rf_wr.idx;
      reg_write_value   <= rf_wr.value;
      mem_write_valid   <= r_mwv;
      mem_write_address <= r_mwa;
      mem_write_value   <= r_mwval;
    end
  end

endmodule

// ----- rtl/flsp_checker.sv -----
// ----------------------------------------------------------------------------
// flsp_checker
// Port-level checks for the five-stage load/store pipeline.
// ----------------------------------------------------------------------------
module flsp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [31:0]                 read_data,
  input logic                        done_res,
  input logic                        reg_write_valid,
  input logic [4:0]                  reg_write_index,
  input logic [31:0]                 reg_write_value,
  input logic                        mem_write_valid,
  input logic [flsp_pkg::ADDR_W-1:0] mem_write_address,
  input logic [31:0]                 mem_write_value
);
  import flsp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(reg_write_value))
    else $error("stalled item changed");

  a_rw_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reg_write_valid |-> reg_write_index == 5'd0 && reg_write_value == 32'd0)
    else $error("register write fields set without write");

  a_mw_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mem_write_valid |-> mem_write_address == '0 && mem_write_value == 32'd0)
    else $error("store fields set without store");

  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !reg_write_valid && !mem_write_valid && read_data == 32'd0)
    else $error("drained pipeline reported activity");

endmodule

bind five_stage_load_store_pipeline flsp_checker u_flsp_checker (.*);

// ----- tb/five_stage_load_store_pipeline_tb.sv -----
// ----------------------------------------------------------------------------
// five_stage_load_store_pipeline_tb
// Loads small programs of addu/subu/lw/sw/branch words through the command
// port, ticks them through, and checks every result item against an
// in-bench model of the pipeline, memories and register file.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module five_stage_load_store_pipeline_tb;
  import flsp_pkg::*;

  typedef struct packed {
    logic [31:0] rdata;
    logic        done;
    logic [31:0] pc;
    logic        rwv;
    logic [4:0]  rwi;
    logic [31:0] rwval;
    logic        mwv;
    logic [9:0]  mwa;
    logic [31:0] mwval;
  } result_t;

  class pipe_scoreboard;
    logic [7:0]  imem[IMEM_BYTES];
    logic [7:0]  dmem[DMEM_BYTES];
    logic [31:0] regs[NREGS];
    logic [31:0] pc;
    logic [4:0]  empty;
    logic [31:0] id_word;
    ex_latch_t   ex_l;
    logic [4:0]  ex_rt;
    mem_latch_t  mem_l;
    wb_latch_t   wb_l;
    result_t     pending[$];
    int          errors;

    function void clear();
      foreach (imem[i]) imem[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      foreach (regs[i]) regs[i] = '0;
      pc = '0;
      empty = 5'b11110;
      id_word = '0;
      ex_l = '0;
      ex_l.add_sel = 1'b1;
      ex_rt = '0;
      mem_l = '0;
      wb_l = '0;
      errors = 0;
    endfunction

    function logic [31:0] word_at(ref logic [7:0] m[1024], input int a);
      logic [31:0] w;
      w = '0;
      for (int i = 0; i < 4; i++) w = {w[23:0], m[(a + i) % 1024]};
      return w;
    endfunction

    function void put_at(ref logic [7:0] m[1024], input int a, input logic [31:0] w);
      for (int i = 0; i < 4; i++) m[(a + i) % 1024] = w[31 - 8 * i -: 8];
    endfunction

    function void advance(ref result_t r);
      wb_latch_t   nw;
      mem_latch_t  nm;
      ex_latch_t   ne;
      logic [4:0]  nf;
      logic [4:0]  nrt;
      logic [31:0] nd, npc, b;
      logic [5:0]  op;
      nw = wb_l; nm = mem_l; ne = ex_l; nd = id_word; npc = pc; nf = '0; nrt = ex_rt;
      r.done = (empty == 5'b11111);
      if (!empty[E_WB] && wb_l.reg_wr) begin
        regs[wb_l.dest] = wb_l.value;
        r.rwv = 1; r.rwi = wb_l.dest; r.rwval = wb_l.value;
      end
      if (empty[E_MEM]) nf[E_WB] = 1;
      else begin
        if (mem_l.store) begin
          put_at(dmem, mem_l.alu % 1024, mem_l.store_val);
          r.mwv = 1; r.mwa = mem_l.alu[9:0]; r.mwval = mem_l.store_val;
        end
        nw.value = mem_l.load ? word_at(dmem, mem_l.alu % 1024) : mem_l.alu;
        nw.dest = mem_l.dest; nw.reg_wr = mem_l.reg_wr;
      end
      if (empty[E_EX]) nf[E_MEM] = 1;
      else begin
        b = ex_l.is_imm ? {{16{ex_l.imm[15]}}, ex_l.imm} : ex_l.op_b;
        nm.store_val = ex_l.op_b;
        nm.alu = ex_l.add_sel ? ex_l.op_a + b : ex_l.op_a - b;
        nm.load = ex_l.load; nm.store = ex_l.store;
        nm.reg_wr = ex_l.reg_wr; nm.dest = ex_l.dest;
      end
      if (empty[E_ID]) nf[E_EX] = 1;
      else begin
        op = id_word[31:26];
        ne.load = (op == OP_LW);
        ne.store = (op == OP_SW);
        ne.reg_wr = !(ne.store || op == OP_BEQ);
        ne.is_imm = (op != OP_RTYPE && op != OP_JUMP && op != OP_BEQ);
        ne.add_sel = !(op == OP_RTYPE && id_word[5:0] == FN_SUBU);
        nrt = id_word[20:16];
        ne.op_a = regs[id_word[25:21]];
        ne.op_b = regs[nrt];
        ne.dest = ne.is_imm ? nrt : id_word[15:11];
        ne.imm = id_word[15:0];
      end
      if (empty[E_IF]) nf[E_ID] = 1'b1;
      else begin
        nd = word_at(imem, pc % 1024);
        npc = pc + 4;
        if (nd == HALT_WORD) begin
          npc = pc;
          nf[E_IF] = 1; nf[E_ID] = 1;
        end
      end
      if (empty[E_IF]) nf[E_IF] = 1;
      empty = nf; wb_l = nw; mem_l = nm; ex_l = ne; ex_rt = nrt; id_word = nd; pc = npc;
    endfunction

    function void note_input(logic [2:0] cmd, logic [9:0] a, logic [31:0] wd);
      result_t r;
      r = '0;
      case (cmd)
        CMD_TICK:     advance(r);
        CMD_WR_INSTR: put_at(imem, a, wd);
        CMD_WR_DATA:  put_at(dmem, a, wd);
        CMD_RD_REG:   r.rdata = regs[a[4:0]];
        CMD_RD_DATA:  r.rdata = word_at(dmem, a);
        default: ;
      endcase
      r.pc = pc;
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result item", $time);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        $display("%0t: exp rd=%h dn=%b pc=%h rw=%b/%0d/%h mw=%b/%h/%h", $time,
                 e.rdata, e.done, e.pc, e.rwv, e.rwi, e.rwval, e.mwv, e.mwa, e.mwval);
        $display("%0t: got rd=%h dn=%b pc=%h rw=%b/%0d/%h mw=%b/%h/%h", $time,
                 got.rdata, got.done, got.pc, got.rwv, got.rwi, got.rwval, got.mwv,
                 got.mwa, got.mwval);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [2:0]  command;
  logic [9:0]  address;
  logic [31:0] write_data;
  logic [31:0] read_data, fetch_pc, reg_write_value, mem_write_value;
  logic        done_res, reg_write_valid, mem_write_valid;
  logic [4:0]  reg_write_index;
  logic [9:0]  mem_write_address;

  pipe_scoreboard sb;
  bit             stim_done;
  bit             hold_now;
  int             cycles = 0;
  int             accepted_items = 0;

  five_stage_load_store_pipeline uut (.*);

  function automatic int uut_items();
    return accepted_items;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  always @(posedge clk) if (!rst && in_valid && !in_stall) accepted_items <= accepted_items + 1;

  // hard stop if the run ever hangs
  initial begin
    wait (cycles >= 2000000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: compare on accept, random stall, one long hold-off
  initial begin
    out_stall = 1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        sb.check_result('{read_data, done_res, fetch_pc, reg_write_valid, reg_write_index,
                          reg_write_value, mem_write_valid, mem_write_address,
                          mem_write_value});
      if (hold_now) out_stall <= 1;
      else if ($urandom_range(0, 3) == 0) out_stall <= 1;
      else out_stall <= 0;
    end
  end

  initial begin
    hold_now = 0;
    wait (cycles > 600);
    @(posedge clk);
    hold_now = 1;
    repeat (300) @(posedge clk);
    hold_now = 0;
  end

  task automatic send(logic [2:0] c, logic [9:0] a, logic [31:0] d);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 1);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; command <= c; address <= a; write_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(c, a, d);
  endtask

  function automatic logic [31:0] rand_instr();
    logic [4:0] rs, rt, rd;
    rs = 5'($urandom_range(0, 7));
    rt = 5'($urandom_range(0, 7));
    rd = 5'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0: return {OP_RTYPE, rs, rt, rd, 5'd0, 6'h21};
      1: return {OP_RTYPE, rs, rt, rd, 5'd0, FN_SUBU};
      2: return {OP_LW, rs, rt, 16'($urandom_range(0, 1023))};
      3: return {OP_SW, rs, rt, 16'($urandom_range(0, 1023))};
      4: return {OP_BEQ, rs, rt, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic run_program(int len);
    logic [9:0] base;
    base = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'd0;
    for (int i = 0; i < len; i++) send(CMD_WR_INSTR, base + 10'(4 * i), rand_instr());
    send(CMD_WR_INSTR, base + 10'(4 * len), HALT_WORD);
    for (int i = 0; i < 3; i++) send(CMD_WR_DATA, 10'($urandom), $urandom);
    for (int i = 0; i < len + 6; i++) begin
      if ($urandom_range(0, 9) == 0) send(CMD_RD_REG, 10'($urandom), '0);
      send(CMD_TICK, 10'($urandom), $urandom);
    end
    send(CMD_RD_DATA, 10'($urandom), '0);
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst = 1; in_valid = 0; command = CMD_TICK; address = '0; write_data = '0;
    repeat (10) @(posedge clk);
    rst <= 0;
    // directed: extremes, halt word, wrap, each op kind
    send(CMD_TICK, '0, '0);
    send(CMD_RD_REG, 10'h3FF, 32'hFFFF_FFFF);
    send(CMD_WR_DATA, 10'h3FE, 32'hDEAD_BEEF);
    send(CMD_RD_DATA, 10'h3FE, '0);
    send(CMD_RD_DATA, 10'h3FF, '0);
    send(3'd5, 10'h155, 32'h5555_5555);
    send(3'd7, 10'h2AA, 32'hAAAA_AAAA);
    send(CMD_WR_INSTR, 10'h004, {OP_LW, 5'd0, 5'd1, 16'hFFFE});
    send(CMD_WR_INSTR, 10'h008, {OP_SW, 5'd0, 5'd1, 16'h0010});
    send(CMD_WR_INSTR, 10'h00C, {OP_RTYPE, 5'd1, 5'd1, 5'd0, 5'd0, FN_SUBU});
    send(CMD_WR_INSTR, 10'h010, {OP_JUMP, 26'h3FFFFFF});
    send(CMD_WR_INSTR, 10'h014, {OP_BEQ, 26'h0});
    send(CMD_WR_INSTR, 10'h018, {6'd8, 5'd1, 5'd2, 16'h7FFF});
    send(CMD_WR_INSTR, 10'h01C, HALT_WORD);
    for (int i = 0; i < 14; i++) send(CMD_TICK, '0, '0);
    send(CMD_RD_REG, 10'd2, '0);
    send(CMD_RD_DATA, 10'h010, '0);
    while (cycles < 2000000) begin
      if (sb.pending.size() == 0 && stim_done) break;
      if (!stim_done) begin
        if ($urandom_range(0, 9) == 0) send(3'($urandom), 10'($urandom), $urandom);
        else run_program($urandom_range(2, 20));
        stim_done = (uut_items() >= 1250);
      end else begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    in_valid <= 0;
    repeat (10) @(posedge clk);
    if (sb.pending.size() != 0 || cycles >= 2000000) begin
      $display("SCOREBOARD MISMATCH");
    end else if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
